@@ hdl/assert_macros.svh @@
// shared assertion helpers, clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ede_pkg.sv @@
package ede_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       clear;
    logic       restart;
    logic       append;
    logic [7:0] symbol;
  } ctl_t;

  // fixed part of the wavefront token handed from cell to cell
  typedef struct packed {
    logic       active;
    logic [7:0] symbol;
  } tok_t;

endpackage

@@ hdl/ede_in_if.sv @@
interface ede_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink (input valid, input command, input symbol, output ready);
endinterface

@@ hdl/ede_out_if.sv @@
interface ede_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] distance;
  logic       overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink (input valid, input distance, input overflow, output ready);
endinterface

@@ hdl/edit_distance_engine_unit.sv @@
// clear, append and report words need no sweep; a report result is valid
// the cycle after its word is accepted and holds until taken
// throughput: a query word below the limit keeps the block busy while its wavefront
// walks the cell chain, one cell per cycle; other words are taken every cycle unless the
// block is busy or a result waits untaken; reset: synchronous, clears both lengths and the
// overflow flag and loads row entry j with j; reference bytes are undefined until written
`include "assert_macros.svh"

module edit_distance_engine_unit #(
  parameter int MAX_LEN = 128
) (
  input  logic      clk,
  input  logic      rst,
  ede_in_if.sink    request,
  ede_out_if.source result
);

  localparam int LW = $clog2(MAX_LEN + 1);

  ede_pkg::ctl_t ctl;
  ede_pkg::tok_t tok   [0:MAX_LEN];
  logic [LW-1:0] left  [0:MAX_LEN];
  logic [LW-1:0] diag  [0:MAX_LEN];
  logic [MAX_LEN:0] cell_valid;

  logic [LW-1:0] ref_len;
  logic [LW-1:0] qlen;
  logic [LW-1:0] last_dist;
  logic          overflow_seen;
  logic          busy;
  logic          out_valid;
  logic [7:0]    distance;
  logic          overflow;

  logic          accepted;
  logic [LW-1:0] dist_sel;
  logic [31:0]   dist_wide;
  logic [7:0]    distance_next;
  logic [31:0]   cell_count;

  assign request.ready   = !rst && !busy && (!out_valid || result.ready);
  assign accepted        = request.valid && request.ready;
  assign result.valid    = out_valid;
  assign result.distance = distance;
  assign result.overflow = overflow;

  always_comb begin
    ctl.clear   = accepted && (request.command == ede_pkg::CMD_CLEAR);
    ctl.append  = accepted && (request.command == ede_pkg::CMD_APPEND);
    ctl.restart = accepted && (request.command != ede_pkg::CMD_QUERY);
    ctl.symbol  = request.symbol;
  end

  // an empty query still holds the restart row, whose last entry is the reference length
  always_comb begin
    dist_sel      = (qlen == '0) ? ref_len : last_dist;
    dist_wide     = 32'(dist_sel);
    distance_next = (dist_wide > 32'd255) ? 8'd255 : dist_wide[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len       <= '0;
      qlen          <= '0;
      overflow_seen <= 1'b0;
      busy          <= 1'b0;
      out_valid     <= 1'b0;
      tok[0].active <= 1'b0;
    end else begin
      tok[0].active <= 1'b0;
      tok[0].symbol <= request.symbol;
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (tok[MAX_LEN].active) begin
        busy <= 1'b0;
      end
      if (accepted) begin
        case (ede_pkg::cmd_t'(request.command))
          ede_pkg::CMD_CLEAR: begin
            ref_len       <= '0;
            qlen          <= '0;
            overflow_seen <= 1'b0;
          end
          ede_pkg::CMD_APPEND: begin
            if (ref_len < LW'(MAX_LEN)) begin
              ref_len <= ref_len + LW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            qlen <= '0;
          end
          ede_pkg::CMD_QUERY: begin
            if (qlen < LW'(MAX_LEN)) begin
              qlen          <= qlen + LW'(1);
              tok[0].active <= 1'b1;
              busy          <= 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          ede_pkg::CMD_REPORT: begin
            out_valid <= 1'b1;
            qlen      <= '0;
          end
          default: begin
            qlen <= qlen;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    left[0]       <= qlen + LW'(1);
    diag[0]       <= qlen;
    if (tok[MAX_LEN].active) begin
      last_dist <= left[MAX_LEN];
    end
    if (accepted && (request.command == ede_pkg::CMD_REPORT)) begin
      distance <= distance_next;
      overflow <= overflow_seen;
    end
  end

  assign cell_valid[0] = 1'b1;

  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    ede_cell #(
      .W   (LW),
      .IDX (j)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (cell_valid[j-1]),
      .valid      (cell_valid[j]),
      .tok_west   (tok[j-1]),
      .left_west  (left[j-1]),
      .diag_west  (diag[j-1]),
      .tok_east   (tok[j]),
      .left_east  (left[j]),
      .diag_east  (diag[j])
    );
  end

  assign cell_count = 32'($countones(cell_valid[MAX_LEN:1]));

  `ASSERT_IMPLIES(a_busy_blocks, clk, rst, busy, !request.ready, "input taken during sweep")
  `ASSERT_NEXT(a_sweep_end, clk, rst, tok[MAX_LEN].active, !busy, "sweep end left block busy")
  `ASSERT_IMPLIES(a_cell_count, clk, rst, 1'b1, cell_count == 32'(ref_len), "cell count mismatch")
  `ASSERT_IMPLIES(a_qlen_range, clk, rst, 1'b1, qlen <= LW'(MAX_LEN), "query length past limit")

endmodule

@@ hdl/ede_cell.sv @@
module ede_cell #(
  parameter int W   = 8,
  parameter int IDX = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  ede_pkg::ctl_t      ctl,
  input  logic               prev_valid,
  output logic               valid,
  input  ede_pkg::tok_t      tok_west,
  input  logic [W-1:0]       left_west,
  input  logic [W-1:0]       diag_west,
  output ede_pkg::tok_t      tok_east,
  output logic [W-1:0]       left_east,
  output logic [W-1:0]       diag_east
);

  logic [7:0]   ref_char;
  logic [W-1:0] row;
  logic [W-1:0] min_lu;
  logic [W-1:0] min_all;
  logic [W-1:0] cost;
  logic         load_char;

  assign load_char = ctl.append && prev_valid && !valid;

  always_comb begin
    min_lu  = (left_west < row) ? left_west : row;
    min_all = (min_lu < diag_west) ? min_lu : diag_west;
    cost    = (ref_char == tok_west.symbol) ? diag_west : min_all + W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= 1'b0;
      row             <= W'(IDX);
      tok_east.active <= 1'b0;
    end else begin
      tok_east.active <= tok_west.active;
      tok_east.symbol <= tok_west.symbol;
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (load_char) begin
        valid <= 1'b1;
      end
      if (ctl.restart) begin
        row <= W'(IDX);
      end else if (tok_west.active && valid) begin
        row <= cost;
      end
    end
  end

  // cells past the reference end pass the left value through unchanged
  always_ff @(posedge clk) begin
    if (load_char) begin
      ref_char <= ctl.symbol;
    end
    left_east       <= valid ? cost : left_west;
    diag_east       <= row;
  end

endmodule
